// ===== rtl/ttf_pkg.sv =====
package ttf_pkg;

  // One vertex beat
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } ttf_in_t;

  // One result beat
  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic        [1:0]  status;
  } ttf_out_t;

  // Divider: 64-bit magnitudes, quotient carries 17 extra fraction bits
  localparam int DivNw   = 64;
  localparam int DivFrac = 17;
  localparam int DivQw   = DivNw + DivFrac;

  // Status bits
  localparam int StDetZero  = 0;
  localparam int StAreaZero = 1;

  // Multiplier operand selects
  typedef enum logic [3:0] {
    OP_DU1, OP_DV1, OP_DU2, OP_DV2,
    OP_E1X, OP_E1Y, OP_E1Z,
    OP_E2X, OP_E2Y, OP_E2Z,
    OP_M0,  OP_M1,  OP_M2
  } ttf_opnd_e;

  typedef struct packed {
    ttf_opnd_e opa;
    ttf_opnd_e opb;
  } ttf_mop_t;

endpackage

// ===== rtl/triangle_tangent_frame_unit.sv =====
// Channel   Ports                        Handshake
// vertex    start, in_i, busy            beat taken when start && !busy
// result    res_valid_o, res_o           one-cycle strobe, no back pressure
//
// Corners 0 and 1 are only stored and give no result; busy stays low.
// Corner 2 starts the sequencer: 23 products on one 32x32 multiplier, up to 32
// normalize shifts, a 32-step square root, and up to nine 81-step divides; the
// bit-serial divider takes most of the busy time.
// Reset clears the corner count and the sequencer; held corners need no reset.
// The result strobe comes in the last busy cycle; the receiver cannot stall it.
module triangle_tangent_frame_unit import ttf_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  ttf_in_t  in_i,
  output logic     busy,
  output logic     res_valid_o,
  output ttf_out_t res_o
);

  localparam int CwEff = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int ExtSh = 32 - CwEff;
  localparam int AccW  = 66;
  localparam int NumRes = 10;
  localparam int NumJobs = 9;
  localparam int TanJobs = 6;
  localparam logic [4:0] LastProd = 5'd19;
  localparam logic [4:0] FirstSq  = 5'd20;
  localparam logic [4:0] LastSq   = 5'd22;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_ACC   = 9'b000000100,
    S_NMAX  = 9'b000001000,
    S_NORM  = 9'b000010000,
    S_SQRT  = 9'b000100000,
    S_DSEL  = 9'b001000000,
    S_DWAIT = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  function automatic logic signed [31:0] take(input logic [31:0] raw);
    take = $signed(raw << ExtSh) >>> ExtSh;
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) sub_sat = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else sub_sat = d[31:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [AccW-1:0] v);
    mag = v[AccW-1] ? 64'(-v) : v[63:0];
  endfunction

  // Product schedule: pairs build det, tangent and bitangent numerators, cross; then three squares
  function automatic ttf_mop_t sched(input logic [4:0] s);
    ttf_mop_t m;
    case (s)
      5'd0:  m = '{OP_DU1, OP_DV2};
      5'd1:  m = '{OP_DV1, OP_DU2};
      5'd2:  m = '{OP_E1X, OP_DV2};
      5'd3:  m = '{OP_E2X, OP_DV1};
      5'd4:  m = '{OP_E1Y, OP_DV2};
      5'd5:  m = '{OP_E2Y, OP_DV1};
      5'd6:  m = '{OP_E1Z, OP_DV2};
      5'd7:  m = '{OP_E2Z, OP_DV1};
      5'd8:  m = '{OP_E2X, OP_DU1};
      5'd9:  m = '{OP_E1X, OP_DU2};
      5'd10: m = '{OP_E2Y, OP_DU1};
      5'd11: m = '{OP_E1Y, OP_DU2};
      5'd12: m = '{OP_E2Z, OP_DU1};
      5'd13: m = '{OP_E1Z, OP_DU2};
      5'd14: m = '{OP_E1Y, OP_E2Z};
      5'd15: m = '{OP_E1Z, OP_E2Y};
      5'd16: m = '{OP_E1Z, OP_E2X};
      5'd17: m = '{OP_E1X, OP_E2Z};
      5'd18: m = '{OP_E1X, OP_E2Y};
      5'd19: m = '{OP_E1Y, OP_E2X};
      5'd20: m = '{OP_M0, OP_M0};
      5'd21: m = '{OP_M1, OP_M1};
      5'd22: m = '{OP_M2, OP_M2};
      default: m = '{OP_DU1, OP_DU1};
    endcase
    return m;
  endfunction

  state_e state_q, state_d;
  logic [1:0] corners_q;
  logic [4:0] step_q;
  logic [3:0] job_q;

  ttf_in_t c0_q, c1_q, cin;
  logic signed [31:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [31:0] du1_q, dv1_q, du2_q, dv2_q;
  logic [63:0] m0_q, m1_q, m2_q;
  logic signed [63:0] prod_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [AccW-1:0] res_q [NumRes];
  logic [31:0] len_q;
  logic signed [31:0] tan_q [3];
  logic signed [31:0] bit_q [3];
  logic signed [31:0] nrm_q [3];

  logic accept, third;
  ttf_mop_t mop;
  logic signed [31:0] opa, opb;
  logic sub, first;
  logic too_big, too_small, area_zero, det_zero;
  logic [3:0] ridx;
  logic signed [AccW-1:0] rsel;
  logic [63:0] msel;
  logic job_live, is_tan, neg;
  logic [DivNw-1:0] dnum, dden;
  logic div_start, div_done;
  logic [DivQw-1:0] quo;
  logic [DivQw:0] rnd, lim;
  logic [31:0] qmag;
  logic signed [31:0] qval;
  logic sq_start, sq_done;
  logic [31:0] root;

  assign accept = start && (state_q == S_IDLE);
  assign third  = corners_q == 2'd2;

  always_comb begin
    cin.pos_x = take(in_i.pos_x);
    cin.pos_y = take(in_i.pos_y);
    cin.pos_z = take(in_i.pos_z);
    cin.tex_u = take(in_i.tex_u);
    cin.tex_v = take(in_i.tex_v);
  end

  // Operand select for the shared multiplier
  assign mop = sched(step_q);

  function automatic logic signed [31:0] pick(input ttf_opnd_e c,
      input logic signed [31:0] du1, input logic signed [31:0] dv1,
      input logic signed [31:0] du2, input logic signed [31:0] dv2,
      input logic signed [31:0] e1x, input logic signed [31:0] e1y,
      input logic signed [31:0] e1z, input logic signed [31:0] e2x,
      input logic signed [31:0] e2y, input logic signed [31:0] e2z,
      input logic [63:0] m0, input logic [63:0] m1, input logic [63:0] m2);
    case (c)
      OP_DU1: pick = du1;
      OP_DV1: pick = dv1;
      OP_DU2: pick = du2;
      OP_DV2: pick = dv2;
      OP_E1X: pick = e1x;
      OP_E1Y: pick = e1y;
      OP_E1Z: pick = e1z;
      OP_E2X: pick = e2x;
      OP_E2Y: pick = e2y;
      OP_E2Z: pick = e2z;
      OP_M0:  pick = m0[31:0];
      OP_M1:  pick = m1[31:0];
      OP_M2:  pick = m2[31:0];
      default: pick = '0;
    endcase
  endfunction

  assign opa = pick(mop.opa, du1_q, dv1_q, du2_q, dv2_q, e1x_q, e1y_q, e1z_q,
                    e2x_q, e2y_q, e2z_q, m0_q, m1_q, m2_q);
  assign opb = pick(mop.opb, du1_q, dv1_q, du2_q, dv2_q, e1x_q, e1y_q, e1z_q,
                    e2x_q, e2y_q, e2z_q, m0_q, m1_q, m2_q);

  // Second term of each pair subtracts; squares all add
  assign sub   = step_q[0] && (step_q <= LastProd);
  assign first = ((step_q <= LastProd) && !step_q[0]) || (step_q == FirstSq);
  assign acc_d = (first ? AccW'(0) : acc_q)
               + (sub ? -AccW'(prod_q) : AccW'(prod_q));

  // Normalize: bring the largest cross magnitude into [2^30, 2^31)
  assign too_big   = |{m0_q[63:31], m1_q[63:31], m2_q[63:31]};
  assign too_small = !(|{m0_q[63:30], m1_q[63:30], m2_q[63:30]});
  assign area_zero = (res_q[7] == '0) && (res_q[8] == '0) && (res_q[9] == '0);
  assign det_zero  = res_q[0] == '0;

  // Divide jobs: 0..5 tangent and bitangent, 6..8 normal
  assign ridx   = (job_q >= 4'(NumJobs)) ? 4'd0 : job_q + 4'd1;
  assign rsel   = res_q[ridx];
  assign is_tan = job_q < 4'(TanJobs);
  always_comb begin
    case (job_q)
      4'd6:    msel = m0_q;
      4'd7:    msel = m1_q;
      default: msel = m2_q;
    endcase
  end
  assign job_live = is_tan ? !det_zero : !area_zero;
  assign neg      = rsel[AccW-1] ^ (is_tan && res_q[0][AccW-1]);
  assign dnum     = is_tan ? mag(rsel) : {msel[49:0], 14'b0};
  assign dden     = is_tan ? mag(res_q[0]) : {32'b0, len_q};
  assign div_start = (state_q == S_DSEL) && (job_q < 4'(NumJobs)) && job_live;

  // Round to nearest, clamp, apply sign
  assign rnd  = ({1'b0, quo} + 1'b1) >> 1;
  assign lim  = (is_tan && neg) ? (DivQw+1)'(33'h0_8000_0000)
                                : (DivQw+1)'(33'h0_7fff_ffff);
  assign qmag = (rnd > lim) ? lim[31:0] : rnd[31:0];
  assign qval = neg ? -$signed(qmag) : $signed(qmag);

  assign sq_start = (state_q == S_ACC) && (step_q == LastSq);

  ttf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dnum),
    .den_i   (dden),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  ttf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (acc_d[63:0]),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept && third) state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC: begin
        if (step_q == LastProd) state_d = S_NMAX;
        else if (step_q == LastSq) state_d = S_SQRT;
        else state_d = S_MUL;
      end
      S_NMAX:  state_d = S_NORM;
      S_NORM: begin
        if (area_zero) state_d = S_DSEL;
        else if (!too_big && !too_small) state_d = S_MUL;
      end
      S_SQRT:  if (sq_done) state_d = S_DSEL;
      S_DSEL: begin
        if (job_q >= 4'(NumJobs)) state_d = S_DONE;
        else if (job_live) state_d = S_DWAIT;
      end
      S_DWAIT: if (div_done) state_d = S_DSEL;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      corners_q <= '0;
      step_q    <= '0;
      job_q     <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        corners_q <= third ? 2'd0 : corners_q + 2'd1;
        step_q    <= '0;
        job_q     <= '0;
      end
      if (state_q == S_ACC) step_q <= step_q + 5'd1;
      if ((state_q == S_DSEL) && (job_q < 4'(NumJobs)) && !job_live) job_q <= job_q + 4'd1;
      if ((state_q == S_DWAIT) && div_done) job_q <= job_q + 4'd1;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!third) begin
        if (corners_q[0]) c1_q <= cin;
        else c0_q <= cin;
      end else begin
        e1x_q <= sub_sat(c1_q.pos_x, c0_q.pos_x);
        e1y_q <= sub_sat(c1_q.pos_y, c0_q.pos_y);
        e1z_q <= sub_sat(c1_q.pos_z, c0_q.pos_z);
        e2x_q <= sub_sat(cin.pos_x, c0_q.pos_x);
        e2y_q <= sub_sat(cin.pos_y, c0_q.pos_y);
        e2z_q <= sub_sat(cin.pos_z, c0_q.pos_z);
        du1_q <= sub_sat(c1_q.tex_u, c0_q.tex_u);
        dv1_q <= sub_sat(c1_q.tex_v, c0_q.tex_v);
        du2_q <= sub_sat(cin.tex_u, c0_q.tex_u);
        dv2_q <= sub_sat(cin.tex_v, c0_q.tex_v);
        for (int i = 0; i < 3; i++) begin
          tan_q[i] <= '0;
          bit_q[i] <= '0;
          nrm_q[i] <= '0;
        end
      end
    end
    if (state_q == S_MUL) prod_q <= opa * opb;
    if (state_q == S_ACC) begin
      acc_q <= acc_d;
      if (sub) res_q[step_q[4:1]] <= acc_d;
    end
    if (state_q == S_NMAX) begin
      m0_q <= mag(res_q[7]);
      m1_q <= mag(res_q[8]);
      m2_q <= mag(res_q[9]);
    end
    if ((state_q == S_NORM) && !area_zero) begin
      if (too_big) begin
        m0_q <= m0_q >> 1;
        m1_q <= m1_q >> 1;
        m2_q <= m2_q >> 1;
      end else if (too_small) begin
        m0_q <= m0_q << 1;
        m1_q <= m1_q << 1;
        m2_q <= m2_q << 1;
      end
    end
    if ((state_q == S_SQRT) && sq_done) len_q <= root;
    if ((state_q == S_DWAIT) && div_done) begin
      case (job_q)
        4'd0: tan_q[0] <= qval;
        4'd1: tan_q[1] <= qval;
        4'd2: tan_q[2] <= qval;
        4'd3: bit_q[0] <= qval;
        4'd4: bit_q[1] <= qval;
        4'd5: bit_q[2] <= qval;
        4'd6: nrm_q[0] <= qval;
        4'd7: nrm_q[1] <= qval;
        4'd8: nrm_q[2] <= qval;
        default: ;
      endcase
    end
  end

  assign busy        = state_q != S_IDLE;
  assign res_valid_o = state_q == S_DONE;

  always_comb begin
    res_o.tangent_x   = tan_q[0];
    res_o.tangent_y   = tan_q[1];
    res_o.tangent_z   = tan_q[2];
    res_o.bitangent_x = bit_q[0];
    res_o.bitangent_y = bit_q[1];
    res_o.bitangent_z = bit_q[2];
    res_o.normal_x    = nrm_q[0];
    res_o.normal_y    = nrm_q[1];
    res_o.normal_z    = nrm_q[2];
    res_o.status             = '0;
    res_o.status[StDetZero]  = det_zero;
    res_o.status[StAreaZero] = area_zero;
  end

endmodule

// ===== rtl/ttf_div.sv =====
module ttf_div import ttf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNw-1:0] num_i,
  input  logic [DivNw-1:0] den_i,
  output logic             done_o,
  output logic [DivQw-1:0] quo_o
);

  localparam int CntW = $clog2(DivQw + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DivNw-1:0] rem_q, rem_d;
  logic [DivNw-1:0] den_q;
  logic [DivQw-1:0] sh_q, sh_d;
  logic [DivNw:0]   rem_sh;
  logic             fit;

  // Shift the next dividend bit in, subtract where it fits
  assign rem_sh = {rem_q, sh_q[DivQw-1]};
  assign fit    = rem_sh >= {1'b0, den_q};

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    sh_d   = sh_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      sh_d  = {num_i, {DivFrac{1'b0}}};
    end else if (run_q) begin
      rem_d = fit ? DivNw'(rem_sh - {1'b0, den_q}) : rem_sh[DivNw-1:0];
      sh_d  = {sh_q[DivQw-2:0], fit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivQw - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

// ===== rtl/ttf_sqrt.sv =====
module ttf_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [63:0] x_q, x_d;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        fit;

  // Bring two radicand bits down per step
  assign rem_sh = {rem_q, x_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fit    = rem_sh >= trial;

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    root_d = root_q;
    x_d    = x_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      root_d = '0;
      x_d    = x_i;
    end else if (run_q) begin
      rem_d  = fit ? 34'(rem_sh - trial) : rem_sh[33:0];
      root_d = {root_q[30:0], fit};
      x_d    = {x_q[61:0], 2'b00};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == 5'd31) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    x_q    <= x_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
